// File: hw/rtl/six_axis_halfstep_stepper_sequencer_defines.svh
// Assertion macros shared by the stepper sequencer RTL.
// Each macro takes a label, an antecedent, a consequent and a message string.
// The clock is clk and the checks are off while rst is high.
`ifndef SIX_AXIS_HALFSTEP_STEPPER_SEQUENCER_DEFINES_SVH
`define SIX_AXIS_HALFSTEP_STEPPER_SEQUENCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ssq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssq_pkg;

  // Defaults for the top-level parameters.
  localparam int NUM_AXES_DEF = 6;
  localparam int POS_BITS_DEF = 32;

  // Fixed field widths.
  localparam int FUNC_W   = 3;
  localparam int AXIS_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int COIL_W   = 4;
  localparam int PHASE_W  = 3;
  localparam int REPORT_AXES = 6;

  localparam logic [PHASE_W-1:0] PHASE_FIRST = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd7;

  // Command codes carried in func. Codes above FUNC_SET_MODE act as a tick.
  localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET_POS   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_DIR   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SET_STEPS = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SET_MODE  = 3'd4;

  // Operands of the set-mode command.
  localparam logic [VALUE_W-1:0] MODE_STOP    = 32'd0;
  localparam logic [VALUE_W-1:0] MODE_REVERSE = 32'd1;
  localparam logic [VALUE_W-1:0] MODE_FORWARD = 32'd2;

  // Command as seen by one axis.
  typedef struct packed {
    logic               sel;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
  } ssq_cmd_t;

  // What one axis reports about its step on this tick.
  typedef struct packed {
    logic              active;
    logic [COIL_W-1:0] coils;
  } ssq_axis_stat_t;

  // Half-step coil pattern for each phase.
  function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      3'd0:    pat = 4'd10;
      3'd1:    pat = 4'd8;
      3'd2:    pat = 4'd9;
      3'd3:    pat = 4'd1;
      3'd4:    pat = 4'd5;
      3'd5:    pat = 4'd4;
      3'd6:    pat = 4'd6;
      3'd7:    pat = 4'd2;
      default: pat = 4'd0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ssq_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module ssq_axis #(
  parameter int POS_BITS = ssq_pkg::POS_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire ssq_pkg::ssq_cmd_t             cmd,
  output ssq_pkg::ssq_axis_stat_t            stat,
  output logic [POS_BITS-1:0]                pos_next,
  output logic [ssq_pkg::VALUE_W-1:0]        rem_next
);
  import ssq_pkg::*;

  logic [POS_BITS-1:0] position;
  logic [VALUE_W-1:0]  remaining;
  logic                forward;
  logic                running;
  logic [PHASE_W-1:0]  phase;

  logic [POS_BITS-1:0] pos_cmd;
  logic [VALUE_W-1:0]  rem_cmd;
  logic                fwd_cmd;
  logic                run_cmd;
  logic                step;
  logic [PHASE_W-1:0]  phase_next;
  logic                fwd_next;
  logic                run_next;

  // Apply the command first.
  always_comb begin
    pos_cmd = position;
    rem_cmd = remaining;
    fwd_cmd = forward;
    run_cmd = running;
    if (cmd.sel) begin
      case (cmd.func)
        FUNC_SET_POS:   pos_cmd = cmd.value[POS_BITS-1:0];
        FUNC_SET_DIR:   fwd_cmd = (cmd.value != '0);
        FUNC_SET_STEPS: rem_cmd = cmd.value;
        FUNC_SET_MODE: begin
          if (cmd.value == MODE_STOP) begin
            run_cmd = 1'b0;
          end else if (cmd.value == MODE_REVERSE) begin
            run_cmd = 1'b1;
            fwd_cmd = 1'b0;
          end else if (cmd.value == MODE_FORWARD) begin
            run_cmd = 1'b1;
            fwd_cmd = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Then take one half step if the axis has work.
  always_comb begin
    step       = run_cmd || (rem_cmd != '0);
    phase_next = phase;
    pos_next   = pos_cmd;
    rem_next   = rem_cmd;
    fwd_next   = fwd_cmd;
    run_next   = run_cmd;
    if (step) begin
      if (fwd_cmd) begin
        if (phase == PHASE_LAST) begin
          phase_next = PHASE_FIRST;
          pos_next   = pos_cmd + POS_BITS'(1);
        end else begin
          phase_next = phase + PHASE_W'(1);
        end
      end else begin
        if (phase == PHASE_FIRST) begin
          phase_next = PHASE_LAST;
          pos_next   = pos_cmd - POS_BITS'(1);
        end else begin
          phase_next = phase - PHASE_W'(1);
        end
      end
      if (!run_cmd && (phase_next == PHASE_FIRST) && (rem_cmd != '0)) begin
        rem_next = rem_cmd - VALUE_W'(1);
      end
    end
    stat.active = step;
    stat.coils  = step ? coil_pattern(phase_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      remaining <= '0;
      forward   <= 1'b1;
      running   <= 1'b0;
      phase     <= PHASE_FIRST;
    end else if (advance) begin
      position  <= pos_next;
      remaining <= rem_next;
      forward   <= fwd_next;
      running   <= run_next;
      phase     <= phase_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/six_axis_halfstep_stepper_sequencer.sv
// Six-axis half-step stepper sequencer.
//
// Input channel (in_valid / in_ready): one word per timer tick, with func, axis
// and cmd_value. A tick may carry one command for one axis (set position, set
// direction, set remaining steps, set mode); the command is applied before the
// tick moves the axes. Axis numbers at or above NUM_AXES are ignored.
// Output channel (out_valid / out_ready): exactly one result word per tick,
// carrying the coil nibbles of all six axes, the position and remaining count
// of the addressed axis after the tick, and a mask of the axes that stepped.
//
// The tick is captured in an input register, all axes update in parallel
// when it leaves that register, and the result lands in the output register.
// One word is accepted every cycle while the receiver keeps up. When the
// receiver stalls, the output register holds its word and one more tick waits
// in the input register; in_ready drops only when both are full. The per-axis
// state advances only when a tick moves from the input register into the
// output register.
//
// Reset (synchronous, rst high) empties both registers, zeroes positions,
// counts and phases, stops every axis and sets every direction to forward.
`timescale 1ns / 1ps
`default_nettype none
`include "six_axis_halfstep_stepper_sequencer_defines.svh"

module six_axis_halfstep_stepper_sequencer #(
  parameter int NUM_AXES = ssq_pkg::NUM_AXES_DEF,
  parameter int POS_BITS = ssq_pkg::POS_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ssq_pkg::FUNC_W-1:0]     func,
  input  wire logic [ssq_pkg::AXIS_W-1:0]     axis,
  input  wire logic [ssq_pkg::VALUE_W-1:0]    cmd_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          coils_axes_0_1,
  output logic [7:0]                          coils_axes_2_3,
  output logic [7:0]                          coils_axes_4_5,
  output logic signed [ssq_pkg::VALUE_W-1:0]  addressed_position,
  output logic [ssq_pkg::VALUE_W-1:0]         addressed_remaining,
  output logic [ssq_pkg::REPORT_AXES-1:0]     active_mask
);
  import ssq_pkg::*;

  // Input register holding the tick that is about to be applied.
  logic               s1_valid;
  logic [FUNC_W-1:0]  s1_func;
  logic [AXIS_W-1:0]  s1_axis;
  logic [VALUE_W-1:0] s1_value;

  // The held tick moves on when the output register is empty or draining.
  logic s1_go;
  logic in_take;
  logic s1_valid_next;
  logic out_valid_next;
  logic axis_ok;

  ssq_axis_stat_t          stat     [NUM_AXES];
  logic [POS_BITS-1:0]     pos_next [NUM_AXES];
  logic [VALUE_W-1:0]      rem_next [NUM_AXES];
  logic [COIL_W-1:0]       nib      [REPORT_AXES];
  logic [REPORT_AXES-1:0]  mask_now;
  logic signed [POS_BITS-1:0] sel_pos;
  logic [VALUE_W-1:0]      sel_rem;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign in_take  = in_valid && in_ready;
  assign axis_ok  = ({1'b0, s1_axis} < (AXIS_W + 1)'(NUM_AXES));

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_take) begin
      s1_valid_next = 1'b1;
    end else if (s1_go) begin
      s1_valid_next = 1'b0;
    end
    out_valid_next = out_valid;
    if (s1_go) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func  <= func;
      s1_axis  <= axis;
      s1_value <= cmd_value;
    end
  end

  // One sequencer per axis; all of them see the tick at the same time.
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    ssq_cmd_t cmd;
    assign cmd.sel   = (s1_axis == AXIS_W'(g));
    assign cmd.func  = s1_func;
    assign cmd.value = s1_value;

    ssq_axis #(
      .POS_BITS (POS_BITS)
    ) u_axis (
      .clk      (clk),
      .rst      (rst),
      .advance  (s1_go),
      .cmd      (cmd),
      .stat     (stat[g]),
      .pos_next (pos_next[g]),
      .rem_next (rem_next[g])
    );
  end

  // Only the first six axes appear in the coil bytes and the mask.
  for (genvar g = 0; g < REPORT_AXES; g++) begin : g_report
    if (g < NUM_AXES) begin : g_on
      assign nib[g]      = stat[g].coils;
      assign mask_now[g] = stat[g].active;
    end else begin : g_off
      assign nib[g]      = '0;
      assign mask_now[g] = 1'b0;
    end
  end

  // Report the addressed axis after its update; an absent axis reports zero.
  always_comb begin
    sel_pos = '0;
    sel_rem = '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      if (axis_ok && (s1_axis == AXIS_W'(k))) begin
        sel_pos = pos_next[k];
        sel_rem = rem_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      coils_axes_0_1      <= {nib[1], nib[0]};
      coils_axes_2_3      <= {nib[3], nib[2]};
      coils_axes_4_5      <= {nib[5], nib[4]};
      addressed_position  <= VALUE_W'(sel_pos);
      addressed_remaining <= sel_rem;
      active_mask         <= mask_now;
    end
  end

  `SSQ_ASSERT_NOW(a_ready_when_empty, !s1_valid, in_ready, "input register empty but not ready")
  `SSQ_ASSERT_NEXT(a_take_fills, in_valid && in_ready, s1_valid, "accepted word not held")
  `SSQ_ASSERT_NEXT(a_go_gives_result, s1_go, out_valid, "applied tick produced no result")
  `SSQ_ASSERT_NEXT(a_stall_holds, s1_valid && !s1_go, s1_valid && $stable(s1_value),
                   "waiting tick lost or changed")

endmodule

`default_nettype wire
